>>> hw/rtl/midpoint_line_rasterizer_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the midpoint line rasterizer
// Shared immediate-style wrappers around concurrent property checks.
// ----------------------------------------------------------------------------
`ifndef MIDPOINT_LINE_RASTERIZER_CORE_ASSERT_SVH
`define MIDPOINT_LINE_RASTERIZER_CORE_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define MLR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define MLR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/mlr_pkg.sv
// ----------------------------------------------------------------------------
// mlr_pkg
// Constants and controller/datapath interface types for the line rasterizer.
// ----------------------------------------------------------------------------
package mlr_pkg;

  localparam int COORD_BITS = 12;
  localparam int MAX_SPAN   = 63;
  localparam int SPAN_BITS  = $clog2(MAX_SPAN + 1);
  localparam int BUF_DEPTH  = MAX_SPAN + 1;
  localparam int PIX_BITS   = 2 * COORD_BITS;
  localparam int DEC_BITS   = 16;

  // controller -> datapath
  typedef struct packed {
    logic capture;        // latch endpoints of an accepted transaction
    logic setup_load;     // load tracing state from the folded endpoints
    logic trace_step;     // write current pixel, advance one step
    logic rd_en;          // issue one buffer read
    logic out_load_ram;   // move buffer read data into the output register
    logic out_load_flag;  // load the rejected-line result
  } mlr_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic too_long;
    logic trace_last;
    logic rd_last;
  } mlr_stat_t;

endpackage

>>> hw/rtl/mlr_ram.sv
// ----------------------------------------------------------------------------
// mlr_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module mlr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hw/rtl/mlr_datapath.sv
// ----------------------------------------------------------------------------
// mlr_datapath
// Octant folding, midpoint stepping, point buffer and output register.
// ----------------------------------------------------------------------------
module mlr_datapath
  import mlr_pkg::*;
(
  input  logic                  clk,
  input  mlr_cmd_t              cmd,
  output mlr_stat_t             status,
  input  logic [COORD_BITS-1:0] start_x,
  input  logic [COORD_BITS-1:0] start_y,
  input  logic [COORD_BITS-1:0] end_x,
  input  logic [COORD_BITS-1:0] end_y,
  output logic [COORD_BITS-1:0] pixel_x,
  output logic [COORD_BITS-1:0] pixel_y,
  output logic                  last_pixel,
  output logic                  span_too_long
);

  // captured endpoints
  logic [COORD_BITS-1:0] x0, y0, x1, y1;

  // folded geometry (setup cycle)
  logic                  rev_c;
  logic [COORD_BITS-1:0] ax, ay, bx, by;
  logic [COORD_BITS-1:0] dx, ady;
  logic                  yneg_c, xmaj_c;
  logic [COORD_BITS-1:0] major_c, minor_c;

  // tracing state
  logic                       rev, yneg, xmaj;
  logic [SPAN_BITS-1:0]       major, minor;
  logic [COORD_BITS-1:0]      px, py;
  logic signed [DEC_BITS-1:0] decision;
  logic [SPAN_BITS-1:0]       wr_idx, rd_idx;
  logic                       s1_last;

  logic [DEC_BITS-1:0]   inc_axis, inc_diag;
  logic                  minor_step;
  logic [SPAN_BITS-1:0]  raddr;
  logic [PIX_BITS-1:0]   rdata;

  always_comb begin
    rev_c   = (x0 > x1) || ((x0 == x1) && (y0 > y1));
    ax      = rev_c ? x1 : x0;
    ay      = rev_c ? y1 : y0;
    bx      = rev_c ? x0 : x1;
    by      = rev_c ? y0 : y1;
    dx      = bx - ax;
    yneg_c  = by < ay;
    ady     = yneg_c ? (ay - by) : (by - ay);
    xmaj_c  = dx >= ady;
    major_c = xmaj_c ? dx : ady;
    minor_c = xmaj_c ? ady : dx;
  end

  assign status.too_long   = major_c > COORD_BITS'(MAX_SPAN);
  assign status.trace_last = wr_idx == major;
  assign status.rd_last    = rd_idx == major;

  assign inc_axis   = DEC_BITS'({minor, 1'b0});
  assign inc_diag   = DEC_BITS'({minor, 1'b0}) - DEC_BITS'({major, 1'b0});
  assign minor_step = !decision[DEC_BITS-1];
  assign raddr      = rev ? (major - rd_idx) : rd_idx;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      x0 <= start_x;
      y0 <= start_y;
      x1 <= end_x;
      y1 <= end_y;
    end

    if (cmd.setup_load) begin
      rev      <= rev_c;
      yneg     <= yneg_c;
      xmaj     <= xmaj_c;
      major    <= SPAN_BITS'(major_c);
      minor    <= SPAN_BITS'(minor_c);
      px       <= ax;
      py       <= ay;
      decision <= DEC_BITS'({minor_c, 1'b0}) - DEC_BITS'(major_c);
      wr_idx   <= '0;
      rd_idx   <= '0;
    end else if (cmd.trace_step && !status.trace_last) begin
      wr_idx <= wr_idx + SPAN_BITS'(1);
      // major axis always steps; minor steps when the decision is not negative
      if (xmaj || minor_step) begin
        px <= px + COORD_BITS'(1);
      end
      if (!xmaj || minor_step) begin
        py <= yneg ? (py - COORD_BITS'(1)) : (py + COORD_BITS'(1));
      end
      decision <= decision + (minor_step ? inc_diag : inc_axis);
    end

    if (cmd.rd_en) begin
      rd_idx  <= rd_idx + SPAN_BITS'(1);
      s1_last <= status.rd_last;
    end

    if (cmd.out_load_flag) begin
      pixel_x       <= '0;
      pixel_y       <= '0;
      last_pixel    <= 1'b1;
      span_too_long <= 1'b1;
    end else if (cmd.out_load_ram) begin
      pixel_x       <= rdata[COORD_BITS-1:0];
      pixel_y       <= rdata[PIX_BITS-1:COORD_BITS];
      last_pixel    <= s1_last;
      span_too_long <= 1'b0;
    end
  end

  mlr_ram #(
    .WIDTH (PIX_BITS),
    .DEPTH (BUF_DEPTH)
  ) u_point_buffer (
    .clk   (clk),
    .we    (cmd.trace_step),
    .waddr (wr_idx),
    .wdata ({py, px}),
    .re    (cmd.rd_en),
    .raddr (raddr),
    .rdata (rdata)
  );

endmodule

>>> hw/rtl/mlr_ctrl.sv
// ----------------------------------------------------------------------------
// mlr_ctrl
// Sequencer: capture, setup, trace into buffer, drain with output stall.
// ----------------------------------------------------------------------------
`include "midpoint_line_rasterizer_core_assert.svh"

module mlr_ctrl
  import mlr_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output mlr_cmd_t  cmd,
  input  mlr_stat_t status
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SETUP = 4'b0010,
    ST_TRACE = 4'b0100,
    ST_DRAIN = 4'b1000
  } state_t;

  state_t state, state_next;
  logic   s1_valid, s1_valid_next, out_valid_next;
  logic   out_free, s1_move;

  assign in_ready = (state == ST_IDLE) && !rst;
  assign out_free = !out_valid || out_ready;
  assign s1_move  = s1_valid && out_free;

  always_comb begin
    cmd               = '0;
    cmd.capture       = in_valid && in_ready;
    cmd.setup_load    = (state == ST_SETUP) && !status.too_long;
    cmd.out_load_flag = (state == ST_SETUP) && status.too_long && !s1_valid && out_free;
    cmd.trace_step    = state == ST_TRACE;
    cmd.out_load_ram  = s1_move;
    // read data parks in the RAM output register while the output is stalled
    cmd.rd_en         = (state == ST_DRAIN) && (!s1_valid || s1_move);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (cmd.capture) state_next = ST_SETUP;
      end
      ST_SETUP: begin
        if (!status.too_long)  state_next = ST_TRACE;
        else if (cmd.out_load_flag) state_next = ST_IDLE;
      end
      ST_TRACE: begin
        if (status.trace_last) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (cmd.rd_en && status.rd_last) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s1_valid_next  = cmd.rd_en ? 1'b1 : (s1_move ? 1'b0 : s1_valid);
    out_valid_next = (cmd.out_load_flag || s1_move) ? 1'b1 :
                     (out_ready ? 1'b0 : out_valid);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      s1_valid  <= s1_valid_next;
      out_valid <= out_valid_next;
    end
  end

  `MLR_ASSERT_NOW(a_flag_needs_empty_pipe, cmd.out_load_flag, !s1_valid && !s1_move,
    "rejected-line result loaded while buffer data in flight")
  `MLR_ASSERT_NOW(a_read_has_room, cmd.rd_en && s1_valid, out_free,
    "buffer read issued with no room for its data")
  `MLR_ASSERT_NEXT(a_trace_to_drain, state == ST_TRACE && status.trace_last,
    state == ST_DRAIN, "trace end did not start the drain")
  `MLR_ASSERT_NEXT(a_long_line_not_traced, state == ST_SETUP && status.too_long,
    state == ST_SETUP || state == ST_IDLE, "over-long line entered tracing")

endmodule

>>> hw/rtl/midpoint_line_rasterizer_core.sv
// ----------------------------------------------------------------------------
// midpoint_line_rasterizer_core
// Midpoint line rasterizer: two endpoints in, one transaction per pixel out.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): start_x/start_y, end_x/end_y of a line.
// Output channel (out_valid/out_ready): pixel_x/pixel_y per pixel, in order
// from the start endpoint to the end endpoint; last_pixel marks the final
// pixel. A line whose major span exceeds MAX_SPAN gives a single transaction
// with pixel 0,0, last_pixel and span_too_long set.
// Sequence for a line of n = span+1 pixels: after acceptance a setup step,
// a trace pass writing the n pixels into the point buffer, then a drain pass
// reading them back at one pixel per cycle while the receiver does not stall.
// The buffer's single read port and its registered read set the drain rate.
// in_ready is high only when the sequencer is idle; a new line may be taken
// while the previous line's last pixels still sit in the output stages.
// A stalled receiver holds the output register and the RAM read register;
// reads stop until space frees. Reset returns the sequencer to idle and
// empties the output stages; the buffer contents are not cleared.
// ----------------------------------------------------------------------------
module midpoint_line_rasterizer_core
  import mlr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [COORD_BITS-1:0] start_x,
  input  logic [COORD_BITS-1:0] start_y,
  input  logic [COORD_BITS-1:0] end_x,
  input  logic [COORD_BITS-1:0] end_y,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [COORD_BITS-1:0] pixel_x,
  output logic [COORD_BITS-1:0] pixel_y,
  output logic                  last_pixel,
  output logic                  span_too_long
);

  mlr_cmd_t  cmd;
  mlr_stat_t status;

  mlr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .status    (status)
  );

  mlr_datapath u_datapath (
    .clk           (clk),
    .cmd           (cmd),
    .status        (status),
    .start_x       (start_x),
    .start_y       (start_y),
    .end_x         (end_x),
    .end_y         (end_y),
    .pixel_x       (pixel_x),
    .pixel_y       (pixel_y),
    .last_pixel    (last_pixel),
    .span_too_long (span_too_long)
  );

endmodule
